### rtl/core/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

    localparam int CELL_COUNT_DEF = 128;
    localparam int MAX_SHIFTS_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 19;
    localparam int PHASE_W  = 20;
    localparam int COEF_W   = 20;
    localparam int INTEG_W  = 24;

    localparam int MUL_AW   = 48;
    localparam int MUL_BW   = 33;
    localparam int MUL_PW   = 72;

    localparam int DIV_NW   = 48;
    localparam int DIV_DW   = 27;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] PASSIVE_RST = 16'd6971;
    localparam logic [19:0] S1_FREQ_RST = 20'd10479;
    localparam logic [19:0] S1_DAMP_RST = 20'd119370;
    localparam logic [19:0] S2_FREQ_RST = 20'd11236;
    localparam logic [19:0] S2_DAMP_RST = 20'd50764;
    localparam logic [16:0] NSCALE_RST  = 17'd65536;
    localparam logic [31:0] SEED_RST    = 32'h9E37_79B9;

    localparam logic [15:0] SMEAR_Q16  = 16'd50627;
    localparam logic [14:0] NOISE_MUL  = 15'd16777;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASSIVE = 3'd0,
        CFG_S1_FREQ = 3'd1,
        CFG_S1_DAMP = 3'd2,
        CFG_S2_FREQ = 3'd3,
        CFG_S2_DAMP = 3'd4,
        CFG_NSCALE  = 3'd5,
        CFG_SEED    = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SV_DEN,
        ST_SV_DEN_W,
        ST_SV_NUM_W,
        ST_SV_HP_W,
        ST_SV_A_W,
        ST_SV_B_W,
        ST_OP_W,
        ST_EDGE,
        ST_F_W,
        ST_E_MUL,
        ST_E_W,
        ST_SM_W,
        ST_NZ_W,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic        [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

endpackage

### rtl/core/bbd_cell.sv
`timescale 1ns / 1ps

module bbd_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               shift_en,
    input  logic signed [bbd_pkg::SAMPLE_W-1:0] d,
    output logic signed [bbd_pkg::SAMPLE_W-1:0] q
);
    import bbd_pkg::*;

    logic signed [SAMPLE_W-1:0] charge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            charge_reg <= '0;
        end else if (shift_en) begin
            charge_reg <= d;
        end
    end

    assign q = charge_reg;

endmodule

### rtl/core/bbd_mul.sv
`timescale 1ns / 1ps

module bbd_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  bbd_pkg::mul_req_t                  req,
    output logic                               done,
    output logic signed [bbd_pkg::MUL_PW-1:0]   prod
);
    import bbd_pkg::*;

    logic signed [MUL_PW-1:0] acc_reg;
    logic signed [MUL_PW-1:0] a_reg;
    logic        [MUL_BW-1:0] b_reg;
    logic                     run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (req.start) begin
            run_reg <= 1'b1;
        end else if (run_reg && b_reg == '0) begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            a_reg   <= MUL_PW'(req.a);
            b_reg   <= req.b;
        end else if (run_reg && b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done = run_reg && (b_reg == '0);
    assign prod = acc_reg;

endmodule

### rtl/core/bbd_div.sv
`timescale 1ns / 1ps

module bbd_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bbd_pkg::div_req_t           req,
    output logic                        done,
    output logic [bbd_pkg::DIV_NW-1:0]  quo
);
    import bbd_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (req.start) begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(DIV_NW);
        end else if (run_reg) begin
            if (cnt_reg == '0) begin
                run_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end else if (run_reg && cnt_reg != '0) begin
            rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : DIV_DW'(trial);
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign done = run_reg && (cnt_reg == '0);
    assign quo  = quo_reg;

endmodule

### rtl/core/bucket_brigade_delay_line.sv
`timescale 1ns / 1ps
// Each sample runs through four filter sections, the one-pole section and up to MAX_SHIFTS
// line clock edges, all on the shared bit-serial multiplier (one multiplier bit per cycle)
// and the 48-step divider.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; clears cells, filter state and phase, loads default
// registers and the noise register with the seed forced odd.

module bucket_brigade_delay_line #(
    parameter int CELL_COUNT = bbd_pkg::CELL_COUNT_DEF,
    parameter int MAX_SHIFTS = bbd_pkg::MAX_SHIFTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,    // sample_in[15:0], clock_step[34:16]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,    // wet_out[15:0]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bbd_pkg::*;

    localparam int SH_W = $clog2(MAX_SHIFTS + 1);
    localparam logic [PHASE_W-1:0] ONE_EDGE = PHASE_W'(65536);

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MUL_AW-1:0] v);
        if (v > 48'sd32767) begin
            sat16 = 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat24(input logic signed [MUL_AW-1:0] v);
        if (v > 48'sd8388607) begin
            sat24 = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    function automatic logic [14:0] clip_lut(input logic [4:0] i);
        case (i)
            5'd0:    clip_lut = 15'd0;
            5'd1:    clip_lut = 15'd2039;
            5'd2:    clip_lut = 15'd4027;
            5'd3:    clip_lut = 15'd5917;
            5'd4:    clip_lut = 15'd7689;
            5'd5:    clip_lut = 15'd9264;
            5'd6:    clip_lut = 15'd10682;
            5'd7:    clip_lut = 15'd11922;
            5'd8:    clip_lut = 15'd12989;
            5'd9:    clip_lut = 15'd13895;
            5'd10:   clip_lut = 15'd14656;
            5'd11:   clip_lut = 15'd15288;
            5'd12:   clip_lut = 15'd15810;
            5'd13:   clip_lut = 15'd16237;
            5'd14:   clip_lut = 15'd16586;
            5'd15:   clip_lut = 15'd16869;
            5'd16:   clip_lut = 15'd17097;
            default: clip_lut = 15'd0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] soft_clip(input logic signed [MUL_AW-1:0] x);
        logic [MUL_AW-1:0] mag;
        logic [14:0]       m;
        logic [14:0]       lo;
        logic [14:0]       hi;
        logic [25:0]       span;
        logic [15:0]       y;
        mag  = x[MUL_AW-1] ? MUL_AW'(-x) : MUL_AW'(x);
        m    = (mag > 48'd32767) ? 15'h7FFF : mag[14:0];
        lo   = clip_lut({1'b0, m[14:11]});
        hi   = clip_lut(5'({1'b0, m[14:11]} + 5'd1));
        span = 26'(hi - lo) * 26'(m[10:0]);
        y    = 16'(lo) + 16'(span >> 11);
        soft_clip = x[MUL_AW-1] ? -$signed(y) : $signed(y);
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        xorshift = t;
    endfunction

    state_t state_reg, state_next;

    logic [15:0] passive_reg;
    logic [19:0] s1_freq_reg, s1_damp_reg, s2_freq_reg, s2_damp_reg;
    logic [16:0] nscale_reg;
    logic [31:0] noise_reg;
    logic [31:0] nmul_reg;

    logic signed [SAMPLE_W-1:0] x_reg, lim_reg, prior_reg, held_reg, smear_reg, onepole_reg;
    logic        [STEP_W-1:0]   step_reg;
    logic        [PHASE_W-1:0]  phase_reg;
    logic        [SH_W-1:0]     shifts_reg;
    logic        [1:0]          sec_reg;
    logic signed [INTEG_W-1:0]  s1_reg [4];
    logic signed [INTEG_W-1:0]  s2_reg [4];
    logic        [DIV_DW-1:0]   den_reg;
    logic                       neg_reg;
    logic        [16:0]         f_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       m_tvalid_reg;
    logic        [15:0]         m_tdata_reg;

    mul_req_t                 mreq;
    div_req_t                 dreq;
    logic                     mdone, ddone;
    logic signed [MUL_PW-1:0] prod;
    logic        [DIV_NW-1:0] quo;

    logic        [COEF_W-1:0]   g_sel, k_sel;
    logic        [COEF_W:0]     gk;
    logic signed [INTEG_W-1:0]  s1_cur, s2_cur;
    logic signed [MUL_AW-1:0]   pr16, num, hp, bp, lp, lim_sum, e_val;
    logic        [31:0]         num_abs;
    logic signed [SAMPLE_W-1:0] res16, lim_new, clip_val, tail, smear_new;
    logic        [PHASE_W-1:0]  phase_dec;
    logic                       take_edge;
    logic        [31:0]         noise_adv;
    logic signed [25:0]         noise_c;
    logic                       out_free;
    logic                       shift_en;
    logic signed [SAMPLE_W-1:0] cell_q [CELL_COUNT];

    bbd_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mreq), .done(mdone), .prod(prod));
    bbd_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quo(quo));

    genvar gi;
    generate
        for (gi = 0; gi < CELL_COUNT; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                bbd_cell u_cell (.aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                                 .d(clip_val), .q(cell_q[gi]));
            end else begin : g_body
                bbd_cell u_cell (.aclk(aclk), .aresetn(aresetn), .shift_en(shift_en),
                                 .d(cell_q[gi-1]), .q(cell_q[gi]));
            end
        end
    endgenerate

    assign tail = cell_q[CELL_COUNT-1];

    assign g_sel     = sec_reg[0] ? s2_freq_reg : s1_freq_reg;
    assign k_sel     = sec_reg[0] ? s2_damp_reg : s1_damp_reg;
    assign gk        = {1'b0, g_sel} + {1'b0, k_sel};
    assign s1_cur    = s1_reg[sec_reg];
    assign s2_cur    = s2_reg[sec_reg];
    assign pr16      = $signed(prod[63:16]);
    assign num       = MUL_AW'(x_reg) - pr16 - MUL_AW'(s2_cur);
    assign num_abs   = num[MUL_AW-1] ? 32'(-num) : num[31:0];
    assign hp        = neg_reg ? -$signed(quo) : $signed(quo);
    assign bp        = pr16 + MUL_AW'(s1_cur);
    assign lp        = pr16 + MUL_AW'(s2_cur);
    assign res16     = sat16(lp);
    assign lim_new   = sat16(pr16 + MUL_AW'(onepole_reg));
    assign lim_sum   = MUL_AW'(lim_new) + pr16;
    assign phase_dec = phase_reg - ONE_EDGE;
    assign take_edge = (phase_reg >= ONE_EDGE) && (shifts_reg < SH_W'(MAX_SHIFTS));
    assign e_val     = MUL_AW'(lim_reg) + pr16;
    assign clip_val  = soft_clip(e_val);
    assign smear_new = smear_reg + pr16[15:0];
    assign noise_adv = xorshift(noise_reg);
    assign noise_c   = $signed({1'b0, noise_adv[23:0], 1'b0}) - 26'sd16777215;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_SV_DEN;
            ST_SV_DEN:   state_next = ST_SV_DEN_W;
            ST_SV_DEN_W: if (mdone) state_next = ST_SV_NUM_W;
            ST_SV_NUM_W: if (mdone) state_next = ST_SV_HP_W;
            ST_SV_HP_W:  if (ddone) state_next = ST_SV_A_W;
            ST_SV_A_W:   if (mdone) state_next = ST_SV_B_W;
            ST_SV_B_W: begin
                if (mdone) begin
                    case (sec_reg)
                        2'd1:    state_next = ST_OP_W;
                        2'd3:    state_next = ST_OUT;
                        default: state_next = ST_SV_DEN;
                    endcase
                end
            end
            ST_OP_W:     if (mdone) state_next = ST_EDGE;
            ST_EDGE: begin
                if (!take_edge) begin
                    state_next = ST_SV_DEN;
                end else if (step_reg != '0) begin
                    state_next = ST_F_W;
                end else begin
                    state_next = ST_E_MUL;
                end
            end
            ST_F_W:      if (ddone) state_next = ST_E_MUL;
            ST_E_MUL:    state_next = ST_E_W;
            ST_E_W:      if (mdone) state_next = ST_SM_W;
            ST_SM_W:     if (mdone) state_next = ST_NZ_W;
            ST_NZ_W:     if (mdone) state_next = ST_EDGE;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mreq     = '0;
        dreq     = '0;
        shift_en = 1'b0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SV_DEN: begin
                mreq.start = 1'b1;
                mreq.a     = MUL_AW'(g_sel);
                mreq.b     = MUL_BW'(gk);
            end
            ST_SV_DEN_W: begin
                mreq.start = mdone;
                mreq.a     = MUL_AW'(s1_cur);
                mreq.b     = MUL_BW'(gk);
            end
            ST_SV_NUM_W: begin
                dreq.start    = mdone;
                dreq.dividend = {num_abs, 16'd0};
                dreq.divisor  = den_reg;
            end
            ST_SV_HP_W: begin
                mreq.start = ddone;
                mreq.a     = hp;
                mreq.b     = MUL_BW'(g_sel);
            end
            ST_SV_A_W: begin
                mreq.start = mdone;
                mreq.a     = bp;
                mreq.b     = MUL_BW'(g_sel);
            end
            ST_SV_B_W: begin
                mreq.start = mdone && (sec_reg == 2'd1);
                mreq.a     = MUL_AW'(res16) - MUL_AW'(onepole_reg);
                mreq.b     = MUL_BW'(passive_reg);
            end
            ST_EDGE: begin
                dreq.start    = take_edge && (step_reg != '0);
                dreq.dividend = DIV_NW'({phase_dec, 16'd0});
                dreq.divisor  = DIV_DW'(step_reg);
            end
            ST_E_MUL: begin
                mreq.start = 1'b1;
                mreq.a     = MUL_AW'(prior_reg) - MUL_AW'(lim_reg);
                mreq.b     = MUL_BW'(f_reg);
            end
            ST_E_W: begin
                shift_en   = mdone;
                mreq.start = mdone;
                mreq.a     = MUL_AW'(tail) - MUL_AW'(smear_reg);
                mreq.b     = MUL_BW'(SMEAR_Q16);
            end
            ST_SM_W: begin
                mreq.start = mdone;
                mreq.a     = MUL_AW'(noise_c);
                mreq.b     = MUL_BW'(nmul_reg);
            end
            default: begin
                mreq = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            passive_reg <= PASSIVE_RST;
            s1_freq_reg <= S1_FREQ_RST;
            s1_damp_reg <= S1_DAMP_RST;
            s2_freq_reg <= S2_FREQ_RST;
            s2_damp_reg <= S2_DAMP_RST;
            nscale_reg  <= NSCALE_RST;
            noise_reg   <= SEED_RST | 32'd1;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PASSIVE: passive_reg <= cfg_data[15:0];
                CFG_S1_FREQ: s1_freq_reg <= cfg_data[19:0];
                CFG_S1_DAMP: s1_damp_reg <= cfg_data[19:0];
                CFG_S2_FREQ: s2_freq_reg <= cfg_data[19:0];
                CFG_S2_DAMP: s2_damp_reg <= cfg_data[19:0];
                CFG_NSCALE:  nscale_reg  <= cfg_data[16:0];
                CFG_SEED:    noise_reg   <= cfg_data | 32'd1;
                default: ;
            endcase
        end else if (state_reg == ST_SM_W && mdone) begin
            noise_reg <= noise_adv;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        nmul_reg <= 32'(nscale_reg) * 32'(NOISE_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            prior_reg   <= '0;
            held_reg    <= '0;
            smear_reg   <= '0;
            onepole_reg <= '0;
            shifts_reg  <= '0;
            sec_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                s1_reg[i] <= '0;
                s2_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        x_reg    <= $signed(s_tdata[15:0]);
                        step_reg <= s_tdata[34:16];
                        sec_reg  <= 2'd0;
                    end
                end
                ST_SV_DEN_W: begin
                    if (mdone) begin
                        den_reg <= DIV_DW'(65536) + DIV_DW'(prod[42:16]);
                    end
                end
                ST_SV_NUM_W: begin
                    if (mdone) begin
                        neg_reg <= num[MUL_AW-1];
                    end
                end
                ST_SV_A_W: begin
                    if (mdone) begin
                        s1_reg[sec_reg] <= sat24(pr16 + bp);
                    end
                end
                ST_SV_B_W: begin
                    if (mdone) begin
                        s2_reg[sec_reg] <= sat24(pr16 + lp);
                        case (sec_reg)
                            2'd0, 2'd2: begin
                                x_reg   <= res16;
                                sec_reg <= sec_reg + 2'd1;
                            end
                            2'd1:    lim_reg <= res16;
                            default: y_reg   <= res16;
                        endcase
                    end
                end
                ST_OP_W: begin
                    if (mdone) begin
                        lim_reg     <= lim_new;
                        onepole_reg <= sat16(lim_sum);
                        phase_reg   <= phase_reg + PHASE_W'(step_reg);
                        shifts_reg  <= '0;
                    end
                end
                ST_EDGE: begin
                    if (take_edge) begin
                        phase_reg  <= phase_dec;
                        shifts_reg <= shifts_reg + 1'b1;
                        f_reg      <= '0;
                    end else begin
                        if (phase_reg >= ONE_EDGE) begin
                            phase_reg <= {{(PHASE_W-16){1'b0}}, phase_reg[15:0]};
                        end
                        prior_reg <= lim_reg;
                        x_reg     <= held_reg;
                        sec_reg   <= 2'd2;
                    end
                end
                ST_F_W: begin
                    if (ddone) begin
                        f_reg <= (quo > DIV_NW'(65536)) ? 17'd65536 : quo[16:0];
                    end
                end
                ST_SM_W: begin
                    if (mdone) begin
                        smear_reg <= smear_new;
                    end
                end
                ST_NZ_W: begin
                    if (mdone) begin
                        held_reg <= sat16(MUL_AW'(smear_reg) + MUL_AW'($signed(prod[71:50])));
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= y_reg;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### tb/bbd_wet_checker.sv
`timescale 1ns / 1ps

module bbd_wet_checker #(
    parameter int CELL_COUNT = bbd_pkg::CELL_COUNT_DEF,
    parameter int MAX_SHIFTS = bbd_pkg::MAX_SHIFTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [39:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [15:0]                    m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import bbd_pkg::*;

    localparam int CLIP_LUT [17] = '{
        0, 2039, 4027, 5917, 7689, 9264, 10682, 11922, 12989,
        13895, 14656, 15288, 15810, 16237, 16586, 16869, 17097
    };

    logic [15:0] k_passive;
    logic [19:0] k_s1_freq, k_s1_damp, k_s2_freq, k_s2_damp;
    logic [16:0] k_nscale;

    logic signed [15:0] cells [CELL_COUNT];
    int          wr_ptr;
    logic [19:0] phase;
    int          prev_lim, held, smear, onepole;
    int          integ [8];
    logic [31:0] lfsr;

    logic signed [15:0] wet_expected [$];

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int soft_clip(input int x);
        int m, i, fr, y;
        m  = x < 0 ? -x : x;
        if (m > 32767) m = 32767;
        i  = m >> 11;
        fr = m & 2047;
        y  = CLIP_LUT[i] + (((CLIP_LUT[i + 1] - CLIP_LUT[i]) * fr) >>> 11);
        return x < 0 ? -y : y;
    endfunction

    task automatic svf_section(input int base, input longint x, input logic [19:0] g,
                               input logic [19:0] k, output int y);
        longint s1, s2, gi, gk, den, num, hp, a, bp, b, lp;
        s1  = integ[base];
        s2  = integ[base + 1];
        gi  = longint'(g);
        gk  = longint'(g) + longint'(k);
        den = 65536 + ((gi * gk) >>> 16);
        num = x - ((gk * s1) >>> 16) - s2;
        hp  = (num * 65536) / den;
        a   = (gi * hp) >>> 16;
        bp  = a + s1;
        integ[base] = int'(sat(a + bp, -8388608, 8388607));
        b   = (gi * bp) >>> 16;
        lp  = b + s2;
        integ[base + 1] = int'(sat(b + lp, -8388608, 8388607));
        y   = int'(sat(lp, -32768, 32767));
    endtask

    function automatic int next_noise();
        logic [31:0] s;
        longint c;
        s = lfsr;
        s ^= s << 13;
        s ^= s >> 17;
        s ^= s << 5;
        lfsr = s;
        c = 2 * longint'(s & 32'hFF_FFFF) - 16777215;
        return int'((c * longint'(k_nscale) * longint'(NOISE_MUL)) >>> 50);
    endfunction

    task automatic predict_wet(input logic signed [15:0] x, input logic [18:0] step);
        int lim, y, e, leaving, shifts;
        longint d, f;
        svf_section(0, x, k_s1_freq, k_s1_damp, lim);
        svf_section(2, lim, k_s2_freq, k_s2_damp, lim);
        d = (longint'(lim - onepole) * longint'(k_passive)) >>> 16;
        lim = int'(sat(d + onepole, -32768, 32767));
        onepole = int'(sat(lim + d, -32768, 32767));
        phase = phase + step;
        shifts = 0;
        while (phase >= 20'h10000 && shifts < MAX_SHIFTS) begin
            phase = phase - 20'h10000;
            shifts++;
            f = 0;
            if (step != 0) begin
                f = (longint'(phase) << 16) / longint'(step);
                if (f > 65536) f = 65536;
            end
            e = lim + int'((longint'(prev_lim - lim) * f) >>> 16);
            e = soft_clip(e);
            wr_ptr = (wr_ptr + 1 < CELL_COUNT) ? wr_ptr + 1 : 0;
            leaving = cells[wr_ptr];
            cells[wr_ptr] = 16'(e);
            smear += int'((longint'(leaving - smear) * longint'(SMEAR_Q16)) >>> 16);
            held = int'(sat(longint'(smear) + next_noise(), -32768, 32767));
        end
        if (phase >= 20'h10000) phase = phase & 20'hFFFF;
        prev_lim = lim;
        svf_section(4, held, k_s1_freq, k_s1_damp, y);
        svf_section(6, y, k_s2_freq, k_s2_damp, y);
        wet_expected.push_back(16'(y));
    endtask

    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (!aresetn) begin
            k_passive = PASSIVE_RST;
            k_s1_freq = S1_FREQ_RST;
            k_s1_damp = S1_DAMP_RST;
            k_s2_freq = S2_FREQ_RST;
            k_s2_damp = S2_DAMP_RST;
            k_nscale  = NSCALE_RST;
            lfsr      = SEED_RST | 32'd1;
            foreach (cells[i]) cells[i] = '0;
            foreach (integ[i]) integ[i] = 0;
            wr_ptr = 0;
            phase = '0;
            prev_lim = 0;
            held = 0;
            smear = 0;
            onepole = 0;
            fail_count = 0;
            wet_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PASSIVE: k_passive = cfg_data[15:0];
                    CFG_S1_FREQ: k_s1_freq = cfg_data[19:0];
                    CFG_S1_DAMP: k_s1_damp = cfg_data[19:0];
                    CFG_S2_FREQ: k_s2_freq = cfg_data[19:0];
                    CFG_S2_DAMP: k_s2_damp = cfg_data[19:0];
                    CFG_NSCALE:  k_nscale  = cfg_data[16:0];
                    CFG_SEED:    lfsr      = cfg_data | 32'd1;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_wet(s_tdata[15:0], s_tdata[34:16]);
            if (m_tvalid && m_tready) begin
                if (wet_expected.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result wet_out=%0d", $signed(m_tdata));
                end else begin
                    want = wet_expected.pop_front();
                    if (want !== m_tdata) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("wet_out mismatch: expected %0d got %0d",
                                     want, $signed(m_tdata));
                    end
                end
            end
        end
        pending = wet_expected.size();
    end

endmodule

### tb/tb_bucket_brigade_delay_line.sv
`timescale 1ns / 1ps

module tb_bucket_brigade_delay_line;
    import bbd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [39:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    bit hold_output;

    bucket_brigade_delay_line u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bbd_wet_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("tb_bucket_brigade_delay_line failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, one long hold on request
    initial begin
        bit held_once;
        held_once = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_output && !held_once) begin
                m_tready = 1'b0;
                repeat (5000) @(negedge aclk);
                held_once = 1'b1;
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
            if ($urandom_range(0, 3) != 0) begin
                m_tready = 1'b0;
                repeat (idle_len()) @(negedge aclk);
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] x, input logic [18:0] step,
                               input int gap);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {5'd0, step, x};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        s_tvalid  = 1'b0;
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_all(input logic [15:0] pc, input logic [19:0] f1, input logic [19:0] d1,
                             input logic [19:0] f2, input logic [19:0] d2,
                             input logic [16:0] ns, input logic [31:0] seed);
        drain();
        write_reg(CFG_PASSIVE, pc);
        write_reg(CFG_S1_FREQ, f1);
        write_reg(CFG_S1_DAMP, d1);
        write_reg(CFG_S2_FREQ, f2);
        write_reg(CFG_S2_DAMP, d2);
        write_reg(CFG_NSCALE, ns);
        write_reg(CFG_SEED, seed);
    endtask

    function automatic logic [18:0] rand_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 19'd0;
        if (r < 20) return 19'h7FFFF;
        if (r < 70) return 19'($urandom_range(16384, 98304));
        return 19'($urandom);
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
            send_sample(16'($urandom), rand_step(), idle_len());
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_output = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: extremes, zero step, backlog, partial steps
        send_sample(16'sh7FFF, 19'h10000, 0);
        send_sample(-16'sh8000, 19'h10000, 0);
        send_sample(-16'sh8000, 19'h7FFFF, 0);
        send_sample(16'sh7FFF, 19'h7FFFF, 0);
        send_sample(16'sh7FFF, 19'h7FFFF, 2);
        send_sample(16'sh0000, 19'd0, 0);
        send_sample(16'sh4000, 19'd0, 1);
        send_sample(-16'sh4000, 19'd1, 0);
        send_sample(16'sh5555, 19'h0AAAA, 0);
        send_sample(-16'sh2AAB, 19'h15555, 0);
        send_sample(16'sh0001, 19'h0FFFF, 0);
        send_sample(-16'sh0001, 19'h18000, 3);
        for (int i = 0; i < 8; i++)
            send_sample(16'($urandom), 19'h08000, 0);

        // all zero, including an even seed and an unmapped index
        write_all(16'd0, 20'd0, 20'd0, 20'd0, 20'd0, 17'd0, 32'd0);
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        send_sample(16'sh7FFF, 19'h7FFFF, 0);
        send_sample(-16'sh8000, 19'h7FFFF, 0);
        random_run(20);

        // all ones, noise scale beyond its range
        write_all(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 17'h1FFFF,
                  32'hFFFF_FFFE);
        send_sample(16'sh7FFF, 19'h7FFFF, 0);
        send_sample(-16'sh8000, 19'h7FFFF, 0);
        random_run(20);

        // defaults, long output hold while input keeps coming
        write_all(PASSIVE_RST, S1_FREQ_RST, S1_DAMP_RST, S2_FREQ_RST, S2_DAMP_RST,
                  NSCALE_RST, SEED_RST);
        hold_output = 1'b1;
        for (int i = 0; i < 10; i++)
            send_sample(16'($urandom), rand_step(), 0);
        random_run(150);

        for (int p = 0; p < 4; p++) begin
            write_all(16'($urandom), 20'($urandom_range(0, 40000)),
                      20'($urandom_range(20000, 200000)), 20'($urandom_range(0, 40000)),
                      20'($urandom_range(20000, 200000)), 17'($urandom_range(0, 65536)),
                      $urandom);
            random_run(50);
        end

        drain();
        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("tb_bucket_brigade_delay_line passed");
        else
            $display("tb_bucket_brigade_delay_line failed");
        $finish;
    end

endmodule
